### src/modular_exponentiation_defines.svh
// assertion macros shared by the checker
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MEXP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int BASE_WIDTH     = 32;
    localparam int EXP_IN_WIDTH   = 63;
    localparam int OUT_WIDTH      = 32;
    localparam int CFG_WIDTH      = 32;
    localparam int ADDR_WIDTH     = 3;
    localparam int EXP_WIDTH_DEF  = 63;
    localparam int MOD_WIDTH_DEF  = 32;
    localparam int BIT_CNT_WIDTH  = $clog2(BASE_WIDTH);

    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

    // register index taken from the word address
    localparam logic REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_OUT
    } t_state;

endpackage

### src/mexp_modmul.sv
`timescale 1ns / 1ps

// interleaved shift-add modular multiplier, one multiplier bit per cycle, msb first
module mexp_modmul #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [MOD_WIDTH-1:0]            i_a,
    input  logic [mexp_pkg::BASE_WIDTH-1:0] i_b,
    input  logic [MOD_WIDTH:0]              i_mod,
    output logic                            o_done,
    output logic [MOD_WIDTH-1:0]            o_res
);

    localparam int CW = mexp_pkg::BIT_CNT_WIDTH;
    localparam int BW = mexp_pkg::BASE_WIDTH;

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [MOD_WIDTH-1:0] r_a;
    logic [BW-1:0]        r_b;
    logic [MOD_WIDTH-1:0] r_prod;
    logic [MOD_WIDTH-1:0] n_prod;

    logic [MOD_WIDTH:0]   dbl;
    logic [MOD_WIDTH:0]   dbl_red;
    logic [MOD_WIDTH+1:0] sum;
    logic [MOD_WIDTH+1:0] sum_red;

    // partial stays below the modulus, addend is at most the modulus
    always_comb begin
        dbl     = {r_prod, 1'b0};
        dbl_red = (dbl >= i_mod) ? dbl - i_mod : dbl;
        sum     = {1'b0, dbl_red} + (r_b[BW-1] ? {2'b00, r_a} : '0);
        sum_red = (sum >= {1'b0, i_mod}) ? sum - {1'b0, i_mod} : sum;
        n_prod  = sum_red[MOD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW - 1);
                r_a    <= i_a;
                r_b    <= i_b;
                r_prod <= '0;
            end else if (r_busy) begin
                r_prod <= n_prod;
                r_b    <= r_b << 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_prod;

endmodule

### src/mexp_ctrl.sv
`timescale 1ns / 1ps

// square-and-multiply sequencer around the shared multiplier
module mexp_ctrl #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]   i_base,
    input  logic [mexp_pkg::EXP_IN_WIDTH-1:0] i_exponent,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mexp_pkg::OUT_WIDTH-1:0]    o_power_result,
    output logic                              o_mul_start,
    output logic [MOD_WIDTH-1:0]              o_mul_a,
    output logic [mexp_pkg::BASE_WIDTH-1:0]   o_mul_b,
    input  logic                              i_mul_done,
    input  logic [MOD_WIDTH-1:0]              i_mul_res
);

    localparam int BW = mexp_pkg::BASE_WIDTH;
    localparam int OW = mexp_pkg::OUT_WIDTH;

    mexp_pkg::t_state r_state, n_state;
    logic [EXP_WIDTH-1:0] r_exp, n_exp;
    logic [BW-1:0]        r_base, n_base;
    logic [MOD_WIDTH-1:0] r_sq, n_sq;
    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic                 r_start, n_start;
    logic                 r_out_valid, n_out_valid;
    logic [OW-1:0]        r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_base <= n_base;
        r_sq   <= n_sq;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_base      = r_base;
        n_sq        = r_sq;
        n_acc       = r_acc;
        n_start     = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_in_stall  = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mexp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_base  = i_base;
                    n_exp   = EXP_WIDTH'(i_exponent);
                    n_start = 1'b1;
                    n_state = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE: begin
                if (i_mul_done) begin
                    n_sq    = i_mul_res;
                    n_acc   = MOD_WIDTH'(1);
                    n_state = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK: begin
                if (r_exp == '0) begin
                    n_state = mexp_pkg::ST_OUT;
                end else if (r_exp[0]) begin
                    n_start = 1'b1;
                    n_state = mexp_pkg::ST_MUL;
                end else begin
                    n_start = 1'b1;
                    n_state = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL: begin
                if (i_mul_done) begin
                    n_acc = i_mul_res;
                    // last set bit: the trailing square is never used
                    if ((r_exp >> 1) == '0) begin
                        n_state = mexp_pkg::ST_OUT;
                    end else begin
                        n_start = 1'b1;
                        n_state = mexp_pkg::ST_SQR;
                    end
                end
            end
            mexp_pkg::ST_SQR: begin
                if (i_mul_done) begin
                    n_sq    = i_mul_res;
                    n_exp   = r_exp >> 1;
                    n_state = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = OW'(r_acc);
                    n_out_valid = 1'b1;
                    n_state     = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // operands follow the state the start pulse belongs to
    always_comb begin
        case (r_state)
            mexp_pkg::ST_REDUCE: begin
                o_mul_a = MOD_WIDTH'(1);
                o_mul_b = r_base;
            end
            mexp_pkg::ST_MUL: begin
                o_mul_a = r_acc;
                o_mul_b = BW'(r_sq);
            end
            default: begin
                o_mul_a = r_sq;
                o_mul_b = BW'(r_sq);
            end
        endcase
    end

    assign o_mul_start    = r_start;
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out;

endmodule

### src/modular_exponentiation.sv
`timescale 1ns / 1ps

// Modular exponentiation: o_power_result = i_base ** i_exponent mod modulus, by
// right-to-left square-and-multiply. The modulus register sits at byte address 0
// of the APB port (reset 1000000007); a modulus of 0 wraps at 2**MOD_WIDTH. An
// exponent of 0 gives 1. One shared shift-add modular multiplier does all the
// work at one multiplier bit per cycle; each product holds the sequencer through
// a start, one step per multiplier bit and a done. A request first reduces the
// base, then for each exponent bit up to the highest set one runs a check and a
// square, plus a multiply when the bit is set; the square after the highest set
// bit is skipped and the output register is loaded last. The input is stalled
// from acceptance until the result has been loaded into the output register; the
// next request can be taken while that result waits.
module modular_exponentiation #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]   i_base,
    input  logic [mexp_pkg::EXP_IN_WIDTH-1:0] i_exponent,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mexp_pkg::OUT_WIDTH-1:0]    o_power_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mexp_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [mexp_pkg::CFG_WIDTH-1:0]    pwdata,
    output logic [mexp_pkg::CFG_WIDTH-1:0]    prdata,
    output logic                              pready
);

    localparam int AW = mexp_pkg::ADDR_WIDTH;
    localparam int DW = mexp_pkg::CFG_WIDTH;

    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH:0]   mod_ext;
    logic                 reg_sel;
    logic                 mul_start;
    logic                 mul_done;
    logic [MOD_WIDTH-1:0] mul_a;
    logic [MOD_WIDTH-1:0] mul_res;
    logic [mexp_pkg::BASE_WIDTH-1:0] mul_b;

    assign reg_sel = (paddr[AW-1] == mexp_pkg::REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
        end else if (psel && penable && pwrite && reg_sel) begin
            r_mod <= MOD_WIDTH'(pwdata);
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? DW'(r_mod) : '0;

    // zero modulus stands for 2**MOD_WIDTH
    assign mod_ext = (r_mod == '0) ? {1'b1, {MOD_WIDTH{1'b0}}} : {1'b0, r_mod};

    mexp_ctrl #(
        .EXP_WIDTH (EXP_WIDTH),
        .MOD_WIDTH (MOD_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result),
        .o_mul_start    (mul_start),
        .o_mul_a        (mul_a),
        .o_mul_b        (mul_b),
        .i_mul_done     (mul_done),
        .i_mul_res      (mul_res)
    );

    mexp_modmul #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_mod   (mod_ext),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

endmodule

### src/mexp_checker.sv
`timescale 1ns / 1ps

`include "modular_exponentiation_defines.svh"

module mexp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [mexp_pkg::OUT_WIDTH-1:0] o_power_result
);

    `MEXP_ASSERT_NEXT(a_out_valid_held, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `MEXP_ASSERT_NEXT(a_out_data_held, o_out_valid && i_out_stall, $stable(o_power_result), "stalled result changed")
    // a request always keeps the block busy for at least the following cycle
    `MEXP_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "request taken back to back")
    // a new result only appears at the end of a request's work
    `MEXP_ASSERT_SAME(a_result_from_work, $rose(o_out_valid), $past(o_in_stall), "result without work")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_power_result (o_power_result)
);

### tb/sv/tb_modular_exponentiation.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation;

    localparam int BASE_WIDTH   = mexp_pkg::BASE_WIDTH;
    localparam int EXP_IN_WIDTH = mexp_pkg::EXP_IN_WIDTH;
    localparam int OUT_WIDTH    = mexp_pkg::OUT_WIDTH;
    localparam int CFG_WIDTH    = mexp_pkg::CFG_WIDTH;
    localparam int ADDR_WIDTH   = mexp_pkg::ADDR_WIDTH;
    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = mexp_pkg::MODULUS_RESET;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYCLES = 6;
    // overall run limit, well beyond the whole run even if every item took the worst case
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 4400;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 15;
    localparam logic [ADDR_WIDTH-1:0] MODULUS_ADDR = ADDR_WIDTH'(4 * mexp_pkg::REG_MODULUS);
    localparam logic [EXP_IN_WIDTH-1:0] EXP_MAX = {EXP_IN_WIDTH{1'b1}};

    class mexp_scoreboard;
        logic [CFG_WIDTH-1:0] modulus;
        logic [OUT_WIDTH-1:0] expected_powers[$];
        int                   errors;

        function new();
            modulus = MODULUS_RESET;
            errors  = 0;
        endfunction

        function void set_modulus(logic [CFG_WIDTH-1:0] value);
            modulus = value;
        endfunction

        // zero modulus wraps at 2**32
        function logic [63:0] reduce(logic [63:0] v, logic [63:0] m);
            if (m == 64'd0) begin
                return v & 64'hFFFF_FFFF;
            end
            return v % m;
        endfunction

        function logic [OUT_WIDTH-1:0] power_mod(logic [BASE_WIDTH-1:0] base,
                                                 logic [EXP_IN_WIDTH-1:0] exponent);
            logic [63:0]             m;
            logic [63:0]             sq;
            logic [63:0]             acc;
            logic [EXP_IN_WIDTH-1:0] e;
            m   = {32'd0, modulus};
            sq  = reduce({32'd0, base}, m);
            acc = 64'd1;
            e   = exponent;
            while (e != '0) begin
                if (e[0]) begin
                    acc = reduce(acc * sq, m);
                end
                sq = reduce(sq * sq, m);
                e  = e >> 1;
            end
            return acc[OUT_WIDTH-1:0];
        endfunction

        function void note_request(logic [BASE_WIDTH-1:0] base,
                                   logic [EXP_IN_WIDTH-1:0] exponent);
            expected_powers.push_back(power_mod(base, exponent));
        endfunction

        function void check_result(logic [OUT_WIDTH-1:0] got);
            logic [OUT_WIDTH-1:0] want;
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected power_result, expected none, got %08h", $time, got);
                errors++;
                return;
            end
            want = expected_powers.pop_front();
            if (got !== want) begin
                $display("%0t: power_result mismatch, expected %08h, got %08h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [BASE_WIDTH-1:0]   i_base;
    logic [EXP_IN_WIDTH-1:0] i_exponent;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [OUT_WIDTH-1:0]    o_power_result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_WIDTH-1:0]   paddr;
    logic [CFG_WIDTH-1:0]    pwdata;
    logic [CFG_WIDTH-1:0]    prdata;
    logic                    pready;

    mexp_scoreboard sb = new();
    bit             quiet_phase = 1'b0;
    int             out_hold    = 0;
    int             out_count   = 0;
    int             out_seen    = 0;
    int             out_draw    = 0;
    int             cycle_count = 0;

    modular_exponentiation uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_power_result);
            out_count <= out_count + 1;
        end
    end

    // result side: a fresh stall run is drawn after every accepted result
    always @(negedge i_clk) begin
        if (out_count != out_seen) begin
            out_seen    <= out_count;
            out_draw     = quiet_phase ? 0 : $urandom_range(0, 7);
            i_out_stall <= (out_draw > 0);
            out_hold    <= (out_draw > 0) ? out_draw - 1 : 0;
        end else if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_request(logic [BASE_WIDTH-1:0] base, logic [EXP_IN_WIDTH-1:0] exponent);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(base, exponent);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [CFG_WIDTH-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_modulus(value);
        // read back through the same port
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $display("%0t: modulus readback mismatch, expected %08h, got %08h",
                     $time, value, prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [BASE_WIDTH-1:0] pick_base(logic [CFG_WIDTH-1:0] m);
        logic [BASE_WIDTH-1:0] b;
        b = $urandom;
        case ($urandom_range(0, 7))
            0: b = m - 32'd1;
            1: b = m;
            2: b = m + 32'd1;
            3: b = 32'($urandom_range(0, 15));
            4: b = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            default: ;
        endcase
        return b;
    endfunction

    // mostly short exponents to keep the run length down, a fifth use all bits
    function automatic logic [EXP_IN_WIDTH-1:0] pick_exponent();
        logic [EXP_IN_WIDTH-1:0] e;
        int unsigned             len;
        e = EXP_IN_WIDTH'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0, 1: ;
            2: e = '0;
            3: e = EXP_IN_WIDTH'(1) << $urandom_range(0, EXP_IN_WIDTH - 1);
            default: begin
                len = $urandom_range(1, 16);
                e   = e & ((EXP_IN_WIDTH'(1) << len) - EXP_IN_WIDTH'(1));
            end
        endcase
        return e;
    endfunction

    initial begin
        logic [CFG_WIDTH-1:0] phase_mods[PHASE_COUNT];

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_base      = '0;
        i_exponent  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus
        send_request(32'd0, '0);
        send_request(32'hFFFF_FFFF, '0);
        send_request(32'd2, 63'd1);
        send_request(32'hFFFF_FFFF, 63'd1);
        send_request(32'd0, 63'd5);
        send_request(32'd3, EXP_MAX);
        send_request(32'hFFFF_FFFF, EXP_MAX);
        send_request(32'd1000000007, 63'd3);
        send_request(32'd1000000006, 63'd2);
        send_request(32'd2, 63'h4000_0000_0000_0000);
        send_request(32'd7, 63'd1000000006);
        wait_idle();

        // modulus of one: zero exponent still gives one
        write_modulus(32'd1);
        send_request(32'd5, '0);
        send_request(32'd5, 63'd9);
        send_request(32'hFFFF_FFFF, EXP_MAX);
        wait_idle();

        write_modulus(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 63'd2);
        send_request(32'hFFFF_FFFF, 63'd3);
        send_request(32'hFFFF_FFFE, EXP_MAX);
        wait_idle();

        // zero modulus wraps
        write_modulus(32'd0);
        send_request(32'hFFFF_FFFF, 63'd2);
        send_request(32'd3, 63'd40);
        send_request(32'd12345, '0);
        wait_idle();

        phase_mods[0] = $urandom;
        phase_mods[1] = 32'd2;
        phase_mods[2] = 32'hFFFF_FFFF;
        phase_mods[3] = 32'($urandom_range(3, 255));
        phase_mods[4] = 32'd1;
        phase_mods[5] = $urandom | 32'h8000_0000;
        phase_mods[6] = 32'd0;
        phase_mods[7] = 32'd1000000007;

        foreach (phase_mods[p]) begin
            write_modulus(phase_mods[p]);
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(pick_base(phase_mods[p]), pick_exponent());
                if ($urandom_range(0, 19) == 0) begin
                    wait_idle();
                end
            end
            wait_idle();
        end
        quiet_phase = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### modular_exponentiation.f
+incdir+src
src/mexp_pkg.sv
src/mexp_modmul.sv
src/mexp_ctrl.sv
src/modular_exponentiation.sv
src/mexp_checker.sv
tb/sv/tb_modular_exponentiation.sv
